[rtl/core/rgb_box_blur_clipped_core_defines.svh]
// Assertion macros shared by the box blur core.
`ifndef RGB_BOX_BLUR_CLIPPED_CORE_DEFINES_SVH
`define RGB_BOX_BLUR_CLIPPED_CORE_DEFINES_SVH
`ifndef SYNTH
// Check a consequence in the same cycle as its cause.
`define RBB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rbb same-cycle check failed");
// Check a consequence in the cycle after its cause.
`define RBB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rbb next-cycle check failed");
`else
`define RBB_ASSERT_SAME(label, ante, cons)
`define RBB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/core/rbb_pkg.sv]
// Shared types and constants of the box blur core.
package rbb_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_WINDOW_DEF = 15;
    localparam int MAX_HEIGHT     = 4096;

    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int WIN_W      = 4;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = 24;
    localparam int CNT_W      = 24;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int HALF_W     = 3;
    localparam int SPAN_W     = 4;
    localparam int N_W        = 8;
    localparam int SUM_W      = 16;
    localparam int DIV_CNT_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [WID_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [WIN_W-1:0] WINDOW_RST = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_WINDOW = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [WID_W-1:0]  width;
        logic [HGT_W-1:0]  height;
        logic [HALF_W-1:0] half;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SETUP,
        ST_SWEEP,
        ST_FLUSH,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_OUTPUT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic store;
        logic setup;
        logic sweep;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_drain;
        logic in_done;
        logic hit;
        logic ready;
        logic sweep_last;
        logic div_last;
        logic out_free;
    } stat_t;

endpackage

[rtl/core/rgb_box_blur_clipped_core.sv]
// Top level of the RGB clipped box blur core.
// Flow: an item that releases no output returns to idle after the decide state; one that
// releases an output is set up, swept over its clipped window (1 to 225 pixels), flushed,
// divided and then held in the output state until m_tready frees the output register.
// Throughput is one item at a time, set by the one-pixel-per-cycle line store read port and
// the 16-step serial divider. Reset (aresetn low, synchronous) restores 640x480, window 3.
`include "rgb_box_blur_clipped_core_defines.svh"
module rgb_box_blur_clipped_core #(
    parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = rbb_pkg::MAX_WINDOW_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rbb_pkg::PIX_W-1:0]      s_tdata,   // in_red, in_green, in_blue
    input  logic                          s_tuser,   // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rbb_pkg::PIX_W-1:0]      m_tdata,   // out_red, out_green, out_blue
    output logic                          m_tlast,   // frame_last
    input  logic                          cfg_wr_en,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rbb_pkg::*;

    cfg_t  cfg;
    logic  restart;
    cmd_t  cmd;
    stat_t stat;

    rbb_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_WINDOW(MAX_WINDOW)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .cfg      (cfg),
        .restart  (restart)
    );

    rbb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rbb_dpath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_WINDOW(MAX_WINDOW)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .restart (restart),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    // One item in flight: no transfer right after an accepted one
    `RBB_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
    // A loaded result is presented on the next cycle
    `RBB_ASSERT_NEXT(a_load_shows, cmd.out_load, m_tvalid)
    // Datapath commands never overlap
    `RBB_ASSERT_SAME(a_cmd_excl, 1'b1, $onehot0(cmd))

endmodule

[rtl/core/rbb_cfg.sv]
// Configuration registers of the box blur core with saturation and derived half window.
module rbb_cfg #(
    parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = rbb_pkg::MAX_WINDOW_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output rbb_pkg::cfg_t                 cfg,
    output logic                          restart
);
    import rbb_pkg::*;

    localparam int HMAX = (MAX_WINDOW - 1) / 2;

    logic [WID_W-1:0]  width_reg;
    logic [HGT_W-1:0]  height_reg;
    logic [WIN_W-1:0]  window_reg;
    logic [WID_W-1:0]  width_next;
    logic [HGT_W-1:0]  height_next;
    logic [HALF_W-1:0] half_raw;

    // Saturate incoming values
    always_comb begin
        width_next = cfg_wdata[WID_W-1:0];
        if (width_next == '0) begin
            width_next = WID_W'(1);
        end else if (int'(width_next) > MAX_WIDTH) begin
            width_next = WID_W'(MAX_WIDTH);
        end
        height_next = cfg_wdata[HGT_W-1:0];
        if (height_next == '0) begin
            height_next = HGT_W'(1);
        end else if (int'(height_next) > MAX_HEIGHT) begin
            height_next = HGT_W'(MAX_HEIGHT);
        end
    end

    // Hold register values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            window_reg <= WINDOW_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_WIDTH:  width_reg  <= width_next;
                CFG_HEIGHT: height_reg <= height_next;
                CFG_WINDOW: window_reg <= cfg_wdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Restart the frame on any write to a known register
    assign restart = cfg_wr_en &&
                     (cfg_idx_t'(cfg_addr) inside {CFG_WIDTH, CFG_HEIGHT, CFG_WINDOW});

    // An even side rounds up, so half is the side shifted right
    assign half_raw   = window_reg[WIN_W-1:1];
    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;
    assign cfg.half   = (int'(half_raw) > HMAX) ? HALF_W'(HMAX) : half_raw;

endmodule

[rtl/core/rbb_ctrl.sv]
// Controller state machine of the box blur core.
module rbb_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  rbb_pkg::stat_t stat,
    output rbb_pkg::cmd_t  cmd
);
    import rbb_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (stat.is_drain) begin
                    state_next = stat.ready ? ST_SETUP : ST_IDLE;
                end else begin
                    state_next = (!stat.in_done && stat.hit) ? ST_SETUP : ST_IDLE;
                end
            end
            ST_SETUP:    state_next = ST_SWEEP;
            ST_SWEEP: begin
                if (stat.sweep_last) state_next = ST_FLUSH;
            end
            ST_FLUSH:    state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: state_next = ST_DIVIDE;
            ST_DIVIDE: begin
                if (stat.div_last) state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_DECIDE:   cmd.store    = !stat.is_drain && !stat.in_done;
            ST_SETUP:    cmd.setup    = 1'b1;
            ST_SWEEP:    cmd.sweep    = 1'b1;
            ST_DIV_LOAD: cmd.div_load = 1'b1;
            ST_DIVIDE:   cmd.div_step = 1'b1;
            ST_OUTPUT:   cmd.out_load = stat.out_free;
            default: ;
        endcase
    end

endmodule

[rtl/core/rbb_dpath.sv]
// Datapath of the box blur core: line store, position counters, window sweep, divider.
module rbb_dpath #(
    parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = rbb_pkg::MAX_WINDOW_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rbb_pkg::cfg_t            cfg,
    input  logic                     restart,
    input  rbb_pkg::cmd_t            cmd,
    output rbb_pkg::stat_t           stat,
    input  logic [rbb_pkg::PIX_W-1:0] s_tdata,
    input  logic                     s_tuser,
    output logic [rbb_pkg::PIX_W-1:0] m_tdata,
    output logic                     m_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready
);
    import rbb_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(DEPTH);

    logic [PIX_W-1:0] store_mem [DEPTH];

    logic             func_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [CNT_W-1:0] in_cnt_reg;
    logic [CNT_W-1:0] out_cnt_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [AW-1:0]    in_addr_reg;
    logic [AW-1:0]    out_addr_reg;

    logic [AW-1:0]     row_addr_reg;
    logic [AW-1:0]     rd_addr_reg;
    logic [SPAN_W-1:0] rows_left_reg;
    logic [SPAN_W-1:0] cols_reg;
    logic [SPAN_W-1:0] col_cnt_reg;
    logic [N_W-1:0]    n_reg;
    logic              acc_en_reg;
    logic [PIX_W-1:0]  rd_data_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [SUM_W-1:0] sum_reg [NUM_CH];
    logic [N_W-1:0]   rem_reg [NUM_CH];
    logic [SUM_W-1:0] quo_reg [NUM_CH];
    logic [N_W-1:0]   rem_next [NUM_CH];
    logic [SUM_W-1:0] quo_next [NUM_CH];

    logic [PIX_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;
    logic             m_tvalid_reg;

    logic [CNT_W-1:0] w_x;
    logic [CNT_W-1:0] h_x;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] lead;
    logic [HGT_W-1:0] r_max;
    logic [HGT_W-1:0] r_far;
    logic [HGT_W-1:0] r_end;
    logic [COL_W:0]   c_max;
    logic [COL_W:0]   c_far;
    logic [COL_W:0]   c_end;
    logic             last;

    logic [HALF_W-1:0] dr;
    logic [HALF_W-1:0] dn;
    logic [HALF_W-1:0] dc;
    logic [HALF_W-1:0] dm;
    logic [HGT_W-1:0]  rows_below;
    logic [COL_W:0]    cols_right;
    logic [SPAN_W-1:0] rows;
    logic [SPAN_W-1:0] cols;
    logic [AW:0]       offset;
    logic [AW-1:0]     start_addr;
    logic [AW:0]       row_sum;
    logic [AW-1:0]     row_addr_next;
    logic [AW-1:0]     rd_addr_next;
    logic [AW-1:0]     in_addr_next;
    logic [AW-1:0]     out_addr_next;
    logic              col_end;

    // Frame limits and readiness tests
    always_comb begin
        w_x   = CNT_W'(cfg.width);
        h_x   = CNT_W'(cfg.half);
        total = w_x * CNT_W'(cfg.height);
        lead  = h_x * w_x + h_x;
        r_max = cfg.height - HGT_W'(1);
        r_far = HGT_W'(out_row_reg) + HGT_W'(cfg.half);
        r_end = (r_far > r_max) ? r_max : r_far;
        c_max = (COL_W + 1)'(cfg.width) - (COL_W + 1)'(1);
        c_far = (COL_W + 1)'(out_col_reg) + (COL_W + 1)'(cfg.half);
        c_end = (c_far > c_max) ? c_max : c_far;
        last  = (HGT_W'(out_row_reg) == r_max) && ((COL_W + 1)'(out_col_reg) == c_max);
    end

    assign stat.is_drain = func_reg;
    assign stat.in_done  = (in_cnt_reg == total);
    assign stat.hit      = (in_cnt_reg >= out_cnt_reg + lead);
    assign stat.ready    = (CNT_W'(r_end) * w_x + CNT_W'(c_end)) < in_cnt_reg;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    // Clipped window extent and its start address in the circular store
    always_comb begin
        dr = (out_row_reg >= ROW_W'(cfg.half)) ? cfg.half : out_row_reg[HALF_W-1:0];
        dc = (out_col_reg >= COL_W'(cfg.half)) ? cfg.half : out_col_reg[HALF_W-1:0];
        rows_below = r_max - HGT_W'(out_row_reg);
        cols_right = c_max - (COL_W + 1)'(out_col_reg);
        dn = (rows_below >= HGT_W'(cfg.half)) ? cfg.half : rows_below[HALF_W-1:0];
        dm = (cols_right >= (COL_W + 1)'(cfg.half)) ? cfg.half : cols_right[HALF_W-1:0];
        rows = SPAN_W'(dr) + SPAN_W'(dn) + SPAN_W'(1);
        cols = SPAN_W'(dc) + SPAN_W'(dm) + SPAN_W'(1);
        offset = (AW + 1)'(dr) * (AW + 1)'(cfg.width) + (AW + 1)'(dc);
        if ({1'b0, out_addr_reg} >= offset) begin
            start_addr = AW'({1'b0, out_addr_reg} - offset);
        end else begin
            start_addr = AW'({1'b0, out_addr_reg} + DEPTH_X - offset);
        end
    end

    // Sweep address stepping with wrap
    always_comb begin
        row_sum       = {1'b0, row_addr_reg} + (AW + 1)'(cfg.width);
        row_addr_next = (row_sum >= DEPTH_X) ? AW'(row_sum - DEPTH_X) : AW'(row_sum);
        rd_addr_next  = (rd_addr_reg == ADDR_LAST) ? '0 : rd_addr_reg + AW'(1);
        in_addr_next  = (in_addr_reg == ADDR_LAST) ? '0 : in_addr_reg + AW'(1);
        out_addr_next = (out_addr_reg == ADDR_LAST) ? '0 : out_addr_reg + AW'(1);
        col_end       = (col_cnt_reg == cols_reg - SPAN_W'(1));
    end

    assign stat.sweep_last = col_end && (rows_left_reg == SPAN_W'(1));
    assign stat.div_last   = (div_cnt_reg == '1);

    // Line store: write incoming pixels, read the window
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            store_mem[in_addr_reg] <= pix_reg;
        end
        if (cmd.sweep) begin
            rd_data_reg <= store_mem[rd_addr_reg];
        end
    end

    // Latch the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg <= s_tuser;
            pix_reg  <= s_tdata;
        end
    end

    // Input and output positions
    always_ff @(posedge aclk) begin
        if (!aresetn || restart || (cmd.out_load && last)) begin
            in_cnt_reg   <= '0;
            in_addr_reg  <= '0;
            out_cnt_reg  <= '0;
            out_addr_reg <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
        end else begin
            if (cmd.store) begin
                in_cnt_reg  <= in_cnt_reg + CNT_W'(1);
                in_addr_reg <= in_addr_next;
            end
            if (cmd.out_load) begin
                out_cnt_reg  <= out_cnt_reg + CNT_W'(1);
                out_addr_reg <= out_addr_next;
                if ((COL_W + 1)'(out_col_reg) == c_max) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + ROW_W'(1);
                end else begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // Window sweep counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg <= 1'b0;
        end else begin
            acc_en_reg <= cmd.sweep;
        end
        if (cmd.setup) begin
            row_addr_reg  <= start_addr;
            rd_addr_reg   <= start_addr;
            rows_left_reg <= rows;
            cols_reg      <= cols;
            col_cnt_reg   <= '0;
            n_reg         <= N_W'(rows) * N_W'(cols);
        end else if (cmd.sweep) begin
            if (col_end) begin
                col_cnt_reg   <= '0;
                rows_left_reg <= rows_left_reg - SPAN_W'(1);
                row_addr_reg  <= row_addr_next;
                rd_addr_reg   <= row_addr_next;
            end else begin
                col_cnt_reg <= col_cnt_reg + SPAN_W'(1);
                rd_addr_reg <= rd_addr_next;
            end
        end
    end

    // One restoring divide step per channel
    always_comb begin
        logic [N_W:0] shifted;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            shifted = {rem_reg[ch], quo_reg[ch][SUM_W-1]};
            if (shifted >= {1'b0, n_reg}) begin
                rem_next[ch] = N_W'(shifted - {1'b0, n_reg});
                quo_next[ch] = {quo_reg[ch][SUM_W-2:0], 1'b1};
            end else begin
                rem_next[ch] = shifted[N_W-1:0];
                quo_next[ch] = {quo_reg[ch][SUM_W-2:0], 1'b0};
            end
        end
    end

    // Accumulate sums, then divide by the pixel count
    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (cmd.setup) begin
                sum_reg[ch] <= '0;
            end else if (acc_en_reg) begin
                sum_reg[ch] <= sum_reg[ch] + SUM_W'(rd_data_reg[ch*CH_W +: CH_W]);
            end
            if (cmd.div_load) begin
                rem_reg[ch] <= '0;
                quo_reg[ch] <= sum_reg[ch];
            end else if (cmd.div_step) begin
                rem_reg[ch] <= rem_next[ch];
                quo_reg[ch] <= quo_next[ch];
            end
        end
        if (cmd.div_load) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // Output register: load a result, drop it on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {quo_reg[2][CH_W-1:0], quo_reg[1][CH_W-1:0],
                            quo_reg[0][CH_W-1:0]};
            m_tlast_reg <= last;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

[test/testbench.sv]
// Self-checking testbench for the clipped RGB box blur core.
typedef struct {
    logic [23:0] pix;
    logic        last;
} blur_result_t;

class blur_scoreboard;
    localparam int STORE_DEPTH = 1024 * 15;

    logic [23:0]  store [STORE_DEPTH];
    int unsigned  img_w, img_h, win;
    int unsigned  in_row, in_col, out_row, out_col;
    bit           in_done;
    blur_result_t expected [$];
    int           errors;
    int           results;
    int           frames;

    function new();
        img_w = 640;
        img_h = 480;
        win = 3;
        restart();
    endfunction

    function void restart();
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        in_done = 0;
    endfunction

    function int unsigned half_win();
        int unsigned w;
        w = win;
        if (w % 2 == 0) w++;
        return (w / 2 > 7) ? 7 : w / 2;
    endfunction

    // Mirror a register write, saturating as the block does.
    function void write_reg(rbb_pkg::cfg_idx_t idx, logic [12:0] val);
        int unsigned v;
        case (idx)
            rbb_pkg::CFG_WIDTH: begin
                v = val[10:0];
                if (v == 0) v = 1;
                if (v > 1024) v = 1024;
                img_w = v;
            end
            rbb_pkg::CFG_HEIGHT: begin
                v = val;
                if (v == 0) v = 1;
                if (v > 4096) v = 4096;
                img_h = v;
            end
            rbb_pkg::CFG_WINDOW: win = val[3:0];
            default: return;
        endcase
        restart();
    endfunction

    // Average the clipped window of the next output and queue it.
    function void emit();
        int unsigned h, r0, c0, r1, c1, n;
        int unsigned sum [3];
        logic [23:0] p;
        blur_result_t res;
        h = half_win();
        r0 = out_row >= h ? out_row - h : 0;
        c0 = out_col >= h ? out_col - h : 0;
        r1 = out_row + h; if (r1 > img_h - 1) r1 = img_h - 1;
        c1 = out_col + h; if (c1 > img_w - 1) c1 = img_w - 1;
        sum[0] = 0; sum[1] = 0; sum[2] = 0; n = 0;
        for (int unsigned r = r0; r <= r1; r++)
            for (int unsigned c = c0; c <= c1; c++) begin
                p = store[(r * img_w + c) % STORE_DEPTH];
                for (int k = 0; k < 3; k++) sum[k] += p[8*k +: 8];
                n++;
            end
        for (int k = 0; k < 3; k++) res.pix[8*k +: 8] = 8'(sum[k] / n);
        res.last = (out_row == img_h - 1) && (out_col == img_w - 1);
        expected.push_back(res);
        if (res.last) begin
            restart();
            frames++;
        end else if (++out_col >= img_w) begin
            out_col = 0;
            out_row++;
        end
    endfunction

    // Note one accepted input transfer.
    function void note_input(logic drain, logic [23:0] pix);
        int unsigned recv, idx, h, r, c;
        recv = in_done ? img_w * img_h : in_row * img_w + in_col;
        h = half_win();
        if (drain) begin
            r = out_row + h; if (r > img_h - 1) r = img_h - 1;
            c = out_col + h; if (c > img_w - 1) c = img_w - 1;
            if (r * img_w + c < recv) emit();
            return;
        end
        if (in_done) return;
        idx = recv;
        store[idx % STORE_DEPTH] = pix;
        if (++in_col >= img_w) begin
            in_col = 0;
            if (in_row + 1 >= img_h) begin
                in_row = 0;
                in_done = 1;
            end else begin
                in_row++;
            end
        end
        if (idx >= (out_row * img_w + out_col) + h * img_w + h) emit();
    endfunction

    task report(string msg);
        $display("ERROR result %0d: %s", results, msg);
        errors++;
    endtask

    // Compare one result transfer with the oldest expectation.
    task check_output(logic [23:0] pix, logic last);
        blur_result_t e;
        results++;
        if (expected.size() == 0) begin
            report("unexpected output");
            return;
        end
        e = expected.pop_front();
        for (int k = 0; k < 3; k++)
            if (pix[8*k +: 8] !== e.pix[8*k +: 8])
                report($sformatf("channel %0d got %0d want %0d", k, pix[8*k +: 8],
                                 e.pix[8*k +: 8]));
        if (last !== e.last)
            report($sformatf("tlast got %b want %b", last, e.last));
    endtask
endclass

module testbench;
    import rbb_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 300;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    blur_scoreboard sb = new();
    int  items_sent;
    int  idle_cycles;
    bit  quiet;
    bit  hold_req;
    bit  held;

    rgb_box_blur_clipped_core dut (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d results pending", sb.expected.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request.
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 13);
            if (hold_req) begin
                gap = 3000;
                hold_req = 0;
            end
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            sb.check_output(m_tdata, m_tlast);
        end
    end

    // Offer one item after a random gap and wait for its transfer.
    task send(logic drain, logic [23:0] pix);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= drain;
        s_tdata <= pix;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        sb.note_input(drain, pix);
        items_sent++;
    endtask

    function logic [23:0] rand_pix();
        logic [23:0] p;
        p = $urandom;
        for (int k = 0; k < 3; k++)
            case ($urandom_range(0, 7))
                0: p[8*k +: 8] = 8'h00;
                1: p[8*k +: 8] = 8'hff;
                default: ;
            endcase
        return p;
    endfunction

    // Drop valid, let everything drain out, then settle.
    task wait_idle();
        @(posedge aclk);
        s_tvalid <= 0;
        while (sb.expected.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.write_reg(idx, val);
    endtask

    task setup(int w, int h, int win);
        wait_idle();
        write_reg(CFG_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_WINDOW, CFG_DATA_W'(win));
        @(posedge aclk);
    endtask

    // Stream a full frame, with some noise when asked, then drain until tlast.
    task run_frame(bit noisy);
        int start;
        int npix;
        start = sb.frames;
        npix = sb.img_w * sb.img_h;
        for (int i = 0; i < npix; i++) begin
            if (noisy && $urandom_range(0, 9) == 0) send(1, rand_pix());
            send(0, rand_pix());
        end
        if (noisy && $urandom_range(0, 3) == 0) send(0, rand_pix());
        while (sb.frames == start) send(1, rand_pix());
    endtask

    initial begin
        int w, h;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: a drain with nothing ready, then tiny frames with extreme pixels.
        send(1, 24'h000000);
        setup(3, 2, 1);
        send(0, 24'h000000);
        send(0, 24'hffffff);
        send(0, 24'hff00ff);
        send(0, 24'h00ff00);
        send(0, 24'hffffff);
        send(0, 24'h000000);
        send(0, 24'h123456);
        send(1, 24'h000000);
        wait_idle();
        write_reg(cfg_idx_t'(2'd3), 13'h1fff);
        setup(1, 1, 0);
        send(0, 24'hffffff);
        setup(4, 3, 15);
        run_frame(0);
        setup(2, 2, 14);
        run_frame(0);

        // Saturating writes and the largest sizes, only partly streamed.
        setup(2047, 1, 15);
        for (int i = 0; i < 60; i++) send(0, rand_pix());
        send(1, rand_pix());
        send(1, rand_pix());
        setup(1, 8191, 7);
        for (int i = 0; i < 10; i++) send(0, rand_pix());
        send(1, rand_pix());
        send(1, rand_pix());
        setup(0, 0, 2);
        run_frame(1);

        // Random frames, mostly small, with quiet stretches and one long stall.
        while (items_sent < 800) begin
            quiet = ($urandom_range(0, 4) == 0);
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            setup(w, h, $urandom_range(0, 15));
            if (!held && items_sent > 400) begin
                hold_req = 1;
                held = 1;
            end
            repeat ($urandom_range(1, 2)) run_frame(1);
        end

        quiet = 0;
        wait_idle();
        $display("Sent %0d items over %0d frames, checked %0d blurred pixels.",
                 items_sent, sb.frames, sb.results);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[rgb_box_blur_clipped_core.f]
+incdir+rtl/core
rtl/core/rbb_pkg.sv
rtl/core/rbb_cfg.sv
rtl/core/rbb_ctrl.sv
rtl/core/rbb_dpath.sv
rtl/core/rgb_box_blur_clipped_core.sv
test/testbench.sv
